// ===== rtl/hpv_pkg.sv =====
// ----------------------------------------------------------------------------
// hpv_pkg
// Shared types and constants of the hysteresis peak and valley detector.
// ----------------------------------------------------------------------------
`default_nettype none

package hpv_pkg;

  // Sample width of every channel.
  localparam int SAMPLE_BITS = 16;

  // Width of the signed compare path: wide enough for a sample plus or minus
  // the 16-bit hysteresis distance without overflow.
  localparam int CMP_W = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELTA     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [15:0] MIN_DELTA_RST     = 16'd1;
  localparam logic [15:0] BUFFER_LENGTH_RST = 16'd100;

  // Request operation codes.
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Event codes of a result.
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_MAX  = 2'd1,
    EV_MIN  = 2'd2
  } event_kind_t;

  // One input request.
  typedef struct packed {
    logic                          op;
    logic [2:0]                    channel;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_vector;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [2:0]  event_channel;
    event_kind_t event_kind;
    logic [31:0] event_position;
    logic        data_ready;
  } out_item_t;

  // Classified request handed from the front end to the channel engine.
  typedef struct packed {
    logic                          is_sample;
    logic [2:0]                    channel;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [31:0]                   position;
    logic                          data_ready;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/hysteresis_peak_valley_detector.sv =====
// A request is written into the command queue, then processed by the channel
// engine; its result is written into the result queue, whatever the channel.
// Throughput: one request per cycle while the result queue is not full; each
// command is one read-modify-write of the channel engine's state registers.
// Reset: synchronous, active low; clears queues, position, fill count, and
// restores every channel's extremes and the configuration registers.
// ----------------------------------------------------------------------------
// hysteresis_peak_valley_detector
// Multi-channel delta-hysteresis peak and valley detector with queue-style
// request and result channels and a small configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module hysteresis_peak_valley_detector #(
  parameter int NUM_CHANNELS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Request channel
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire hpv_pkg::in_item_t             in_data,
  // Result channel
  input  wire logic                          out_pop,
  output logic                               out_empty,
  output hpv_pkg::out_item_t                 out_data,
  // Configuration port
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [hpv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data
);

  localparam int CMD_W = $bits(hpv_pkg::cmd_t);
  localparam int RES_W = $bits(hpv_pkg::out_item_t);

  logic               req_fire;
  hpv_pkg::cmd_t      cmd_in, cmd_out;
  logic [CMD_W-1:0]   cmd_rd_bits;
  logic               cmd_empty;
  logic [15:0]        min_delta;
  hpv_pkg::out_item_t result;
  logic [RES_W-1:0]   res_rd_bits;
  logic               res_full;
  logic               eng_fire;

  assign req_fire = in_push && !in_full;

  // Front end: counters, configuration and classification.
  hpv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_fire  (req_fire),
    .req       (in_data),
    .cmd       (cmd_in),
    .min_delta (min_delta)
  );

  // Command queue between the front end and the channel engine.
  hpv_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (req_fire),
    .wr_data (cmd_in),
    .full    (in_full),
    .pop     (eng_fire),
    .rd_data (cmd_rd_bits),
    .empty   (cmd_empty)
  );

  assign cmd_out  = hpv_pkg::cmd_t'(cmd_rd_bits);
  assign eng_fire = !cmd_empty && !res_full;

  // Channel engine.
  hpv_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (eng_fire),
    .cmd       (cmd_out),
    .min_delta (min_delta),
    .result    (result)
  );

  // Result queue toward the consumer.
  hpv_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (eng_fire),
    .wr_data (result),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_rd_bits),
    .empty   (out_empty)
  );

  assign out_data = hpv_pkg::out_item_t'(res_rd_bits);

endmodule

`default_nettype wire

// ===== rtl/hpv_fifo.sv =====
// ----------------------------------------------------------------------------
// hpv_fifo
// Small flip-flop queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module hpv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hpv_front.sv =====
// ----------------------------------------------------------------------------
// hpv_front
// Front end: configuration registers, vector position and fill count, and
// classification of each request into a command for the channel engine.
// ----------------------------------------------------------------------------
`default_nettype none

module hpv_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Configuration port
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [hpv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [15:0]                    cfg_data,
  // Accepted request
  input  wire logic                           req_fire,
  input  wire hpv_pkg::in_item_t              req,
  // Command out
  output hpv_pkg::cmd_t                       cmd,
  output logic [15:0]                         min_delta
);

  logic [15:0] min_delta_r;
  logic [15:0] buffer_length_r;
  logic [31:0] vector_position_r, vector_position_nxt;
  logic [15:0] fill_count_r, fill_count_nxt;

  assign cfg_ready = 1'b1;
  assign min_delta = min_delta_r;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_delta_r     <= hpv_pkg::MIN_DELTA_RST;
      buffer_length_r <= hpv_pkg::BUFFER_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hpv_pkg::CFG_MIN_DELTA:     min_delta_r     <= cfg_data;
        hpv_pkg::CFG_BUFFER_LENGTH: buffer_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Position and fill count; a restart clears both.
  always_comb begin
    vector_position_nxt = vector_position_r;
    fill_count_nxt      = fill_count_r;
    if (req.op == hpv_pkg::OP_RESTART) begin
      vector_position_nxt = '0;
      fill_count_nxt      = '0;
    end else if (req.end_of_vector) begin
      vector_position_nxt = vector_position_r + 32'd1;
      if (fill_count_r != 16'hFFFF) begin
        fill_count_nxt = fill_count_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vector_position_r <= '0;
      fill_count_r      <= '0;
    end else if (req_fire) begin
      vector_position_r <= vector_position_nxt;
      fill_count_r      <= fill_count_nxt;
    end
  end

  // Command: samples carry the position before the update, and the ready
  // flag reflects the count after it.
  always_comb begin
    cmd.is_sample  = (req.op == hpv_pkg::OP_SAMPLE);
    cmd.channel    = req.channel;
    cmd.sample     = req.sample;
    cmd.position   = vector_position_r;
    cmd.data_ready = (fill_count_nxt >= buffer_length_r);
  end

endmodule

`default_nettype wire

// ===== rtl/hpv_back.sv =====
// ----------------------------------------------------------------------------
// hpv_back
// Channel engine: per-channel running extremes and hunt direction, updated
// in a single read-modify-write per command, producing one result each.
// ----------------------------------------------------------------------------
`default_nettype none

module hpv_back #(
  parameter int NUM_CHANNELS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fire,
  input  wire hpv_pkg::cmd_t cmd,
  input  wire logic [15:0]   min_delta,
  output hpv_pkg::out_item_t result
);

  localparam int SB       = hpv_pkg::SAMPLE_BITS;
  localparam int CW       = hpv_pkg::CMP_W;
  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CH_CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam int CH_EXT_W = (CH_CNT_W > 3) ? CH_CNT_W : 3;
  localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB - 1){1'b0}}};
  localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB - 1){1'b1}}};

  logic signed [SB-1:0] run_max_r     [NUM_CHANNELS];
  logic signed [SB-1:0] run_min_r     [NUM_CHANNELS];
  logic [31:0]          run_max_pos_r [NUM_CHANNELS];
  logic [31:0]          run_min_pos_r [NUM_CHANNELS];
  logic                 hunting_max_r [NUM_CHANNELS];

  logic [CH_EXT_W-1:0]  ch_ext;
  logic [CH_IDX_W-1:0]  idx;
  logic                 in_range;
  logic                 process;
  logic signed [SB-1:0] max_nxt, min_nxt;
  logic [31:0]          max_pos_nxt, min_pos_nxt;
  logic                 hunt_nxt;
  logic signed [CW-1:0] now_x, max_x, min_x, delta_x;
  hpv_pkg::event_kind_t kind;
  logic [31:0]          ev_pos;

  // Channel decode.
  assign ch_ext   = CH_EXT_W'(cmd.channel);
  assign in_range = (ch_ext < CH_EXT_W'(NUM_CHANNELS));
  assign idx      = ch_ext[CH_IDX_W-1:0];
  assign process  = cmd.is_sample && in_range;

  // Extreme tracking and hysteresis decision for the selected channel.
  always_comb begin
    max_nxt     = run_max_r[idx];
    min_nxt     = run_min_r[idx];
    max_pos_nxt = run_max_pos_r[idx];
    min_pos_nxt = run_min_pos_r[idx];
    hunt_nxt    = hunting_max_r[idx];
    kind        = hpv_pkg::EV_NONE;
    ev_pos      = '0;
    now_x       = CW'(cmd.sample);
    delta_x     = CW'(min_delta);
    if (cmd.sample > max_nxt) begin
      max_nxt     = cmd.sample;
      max_pos_nxt = cmd.position;
    end
    if (cmd.sample < min_nxt) begin
      min_nxt     = cmd.sample;
      min_pos_nxt = cmd.position;
    end
    max_x = CW'(max_nxt);
    min_x = CW'(min_nxt);
    if (hunting_max_r[idx]) begin
      if (now_x < max_x - delta_x) begin
        kind        = hpv_pkg::EV_MAX;
        ev_pos      = max_pos_nxt;
        min_nxt     = cmd.sample;
        min_pos_nxt = cmd.position;
        hunt_nxt    = 1'b0;
      end
    end else begin
      if (now_x > min_x + delta_x) begin
        kind        = hpv_pkg::EV_MIN;
        ev_pos      = min_pos_nxt;
        max_nxt     = cmd.sample;
        max_pos_nxt = cmd.position;
        hunt_nxt    = 1'b1;
      end
    end
    if (!process) begin
      kind   = hpv_pkg::EV_NONE;
      ev_pos = '0;
    end
  end

  // Channel state write-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        run_max_r[c]     <= SAMPLE_MIN;
        run_min_r[c]     <= SAMPLE_MAX;
        run_max_pos_r[c] <= '0;
        run_min_pos_r[c] <= '0;
        hunting_max_r[c] <= 1'b1;
      end
    end else if (fire && process) begin
      run_max_r[idx]     <= max_nxt;
      run_min_r[idx]     <= min_nxt;
      run_max_pos_r[idx] <= max_pos_nxt;
      run_min_pos_r[idx] <= min_pos_nxt;
      hunting_max_r[idx] <= hunt_nxt;
    end
  end

  // Result of this command.
  always_comb begin
    result.event_channel  = cmd.channel;
    result.event_kind     = kind;
    result.event_position = ev_pos;
    result.data_ready     = cmd.data_ready;
  end

endmodule

`default_nettype wire
